/* rtl/usts_pkg.sv */
// shared types and constants for the udp throughput session statistics block
package usts_pkg;

    localparam logic [31:0] USEC_PER_SECOND = 32'd1000000;
    localparam int          QUEUE_DEPTH     = 2;
    localparam int          QPTR_W          = $clog2(QUEUE_DEPTH);
    localparam int          QCNT_W          = $clog2(QUEUE_DEPTH + 1);
    localparam int          DIV_STEPS       = 64;
    localparam int          DIV_CNT_W       = $clog2(DIV_STEPS);

    localparam logic [2:0] EV_SHORT    = 3'd0;
    localparam logic [2:0] EV_STARTED  = 3'd1;
    localparam logic [2:0] EV_COUNTED  = 3'd2;
    localparam logic [2:0] EV_FINISHED = 3'd3;
    localparam logic [2:0] EV_RESENT   = 3'd4;

    typedef struct packed {
        logic signed [31:0] packet_id;
        logic [31:0]        sent_seconds;
        logic [19:0]        sent_microseconds;
        logic [15:0]        packet_length;
        logic [63:0]        arrival_us;
    } t_in_item;

    typedef struct packed {
        logic [2:0]         event_kind;
        logic [31:0]        packets_received;
        logic [31:0]        packets_lost;
        logic [31:0]        packets_out_of_order;
        logic [63:0]        total_bytes;
        logic [63:0]        duration_us;
        logic signed [31:0] jitter_us;
        logic [15:0]        average_packet_size;
    } t_out_item;

    // classified datagram handed from the front to the back
    typedef struct packed {
        logic               is_short;
        logic signed [31:0] id;
        logic [15:0]        len;
        logic [63:0]        arrival;
        logic [31:0]        transit;
    } t_work;

endpackage

/* rtl/usts_ifs.sv */
// valid/ready channel interfaces for datagrams in and statistics out
interface usts_in_if;
    import usts_pkg::*;
    logic     valid;
    logic     ready;
    t_in_item data;
    modport source(output valid, output data, input ready);
    modport sink(input valid, input data, output ready);
endinterface

interface usts_out_if;
    import usts_pkg::*;
    logic      valid;
    logic      ready;
    t_out_item data;
    modport source(output valid, output data, input ready);
    modport sink(input valid, input data, output ready);
endinterface

/* rtl/usts_front.sv */
// front end: takes datagrams, computes sender time and transit, flags short ones
module usts_front #(
    parameter int unsigned HEADER_BYTES = 16
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    usts_in_if.sink          i_rx,
    output logic             o_push_valid,
    input  logic             i_push_ready,
    output usts_pkg::t_work  o_push_data
);
    import usts_pkg::*;

    logic        r_valid;
    t_in_item    r_item;
    logic [31:0] r_sec_us;
    logic [31:0] sent32;

    assign i_rx.ready = !r_valid || i_push_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_rx.ready) begin
            r_valid <= i_rx.valid;
        end
        if (i_rx.valid && i_rx.ready) begin
            r_item   <= i_rx.data;
            // seconds scaled to microseconds, kept modulo 2^32
            r_sec_us <= i_rx.data.sent_seconds * USEC_PER_SECOND;
        end
    end

    assign sent32       = r_sec_us + 32'(r_item.sent_microseconds);
    assign o_push_valid = r_valid;

    always_comb begin
        o_push_data.is_short = r_item.packet_length < 16'(HEADER_BYTES);
        o_push_data.id       = r_item.packet_id;
        o_push_data.len      = r_item.packet_length;
        o_push_data.arrival  = r_item.arrival_us;
        o_push_data.transit  = r_item.arrival_us[31:0] - sent32;
    end
endmodule

/* rtl/usts_queue.sv */
// short queue of classified datagrams between front and back
module usts_queue (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_push_valid,
    output logic             o_push_ready,
    input  usts_pkg::t_work  i_push_data,
    output logic             o_pop_valid,
    input  logic             i_pop_ready,
    output usts_pkg::t_work  o_pop_data
);
    import usts_pkg::*;

    t_work              r_slot [QUEUE_DEPTH];
    logic [QPTR_W-1:0]  r_wr_ptr;
    logic [QPTR_W-1:0]  r_rd_ptr;
    logic [QCNT_W-1:0]  r_count;
    logic               push;
    logic               pop;

    assign o_push_ready = r_count != QCNT_W'(QUEUE_DEPTH);
    assign o_pop_valid  = r_count != '0;
    assign o_pop_data   = r_slot[r_rd_ptr];
    assign push         = i_push_valid && o_push_ready;
    assign pop          = o_pop_valid && i_pop_ready;

    // depth is a power of two, so the pointers wrap on their own
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (push) begin
                r_wr_ptr <= r_wr_ptr + QPTR_W'(1);
            end
            if (pop) begin
                r_rd_ptr <= r_rd_ptr + QPTR_W'(1);
            end
            if (push && !pop) begin
                r_count <= r_count + QCNT_W'(1);
            end else if (pop && !push) begin
                r_count <= r_count - QCNT_W'(1);
            end
        end
        if (push) begin
            r_slot[r_wr_ptr] <= i_push_data;
        end
    end
endmodule

/* rtl/usts_div.sv */
// restoring divider, one quotient bit per cycle, for the average packet size
module usts_div (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_start,
    input  logic [63:0] i_dividend,
    input  logic [31:0] i_divisor,
    output logic        o_done,
    output logic [63:0] o_quotient
);
    import usts_pkg::*;

    logic                 r_busy;
    logic                 r_done;
    logic [DIV_CNT_W-1:0] r_cnt;
    logic [63:0]          r_quo;
    logic [31:0]          r_rem;
    logic [31:0]          r_dvs;
    logic [32:0]          shifted;
    logic                 fits;
    logic [32:0]          rem_next;

    assign shifted  = {r_rem, r_quo[63]};
    assign fits     = shifted >= {1'b0, r_dvs};
    assign rem_next = fits ? shifted - {1'b0, r_dvs} : shifted;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= !i_start && r_busy && (r_cnt == DIV_CNT_W'(DIV_STEPS - 1));
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= '0;
            end else if (r_busy) begin
                r_cnt <= r_cnt + DIV_CNT_W'(1);
                if (r_cnt == DIV_CNT_W'(DIV_STEPS - 1)) begin
                    r_busy <= 1'b0;
                end
            end
        end
        if (i_start) begin
            r_quo <= i_dividend;
            r_rem <= '0;
            r_dvs <= i_divisor;
        end else if (r_busy) begin
            // remainder stays below the divisor, so 32 bits hold it
            r_rem <= rem_next[31:0];
            r_quo <= {r_quo[62:0], fits};
        end
    end

    assign o_done     = r_done;
    assign o_quotient = r_quo;
endmodule

/* rtl/usts_back.sv */
// back end: session state, counters, jitter filter and the result register
module usts_back (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_pop_valid,
    output logic             o_pop_ready,
    input  usts_pkg::t_work  i_pop_data,
    output logic             o_div_start,
    output logic [63:0]      o_div_dividend,
    output logic [31:0]      o_div_divisor,
    input  logic             i_div_done,
    input  logic [63:0]      i_div_quotient,
    usts_out_if.source       o_tx
);
    import usts_pkg::*;

    typedef enum logic [2:0] {
        S_IDLE,
        S_EXEC,
        S_JIT,
        S_DIV,
        S_EMIT
    } t_state;

    typedef enum logic [1:0] {
        PH_IDLE,
        PH_ONGOING,
        PH_COMPLETED
    } t_phase;

    t_state             r_state;
    t_phase             r_phase;
    t_work              r_work;
    logic [2:0]         r_kind;
    logic [15:0]        r_avg;
    logic [63:0]        r_start;
    logic [31:0]        r_count;
    logic [63:0]        r_bytes;
    logic [31:0]        r_lost;
    logic [31:0]        r_reorder;
    logic signed [31:0] r_jitter;
    logic [31:0]        r_prev;
    logic [31:0]        r_expected;
    logic [63:0]        r_final;
    logic               r_tvalid;
    logic signed [33:0] r_diff;
    logic               r_div_start;
    logic               r_out_valid;
    t_out_item          r_out;

    logic signed [31:0] delta;
    logic [32:0]        delta_abs;
    logic signed [33:0] diff;
    logic signed [33:0] diff_rnd;
    logic signed [34:0] jit_sum;
    logic signed [31:0] jit_sat;
    logic               out_free;
    logic               out_load;
    logic               div_go;
    t_out_item          emit_item;

    assign o_pop_ready = r_state == S_IDLE;
    assign out_free    = !r_out_valid || o_tx.ready;
    assign out_load    = (r_state == S_EMIT) && out_free;
    // a finish with counted packets needs the average size divide
    assign div_go      = (r_state == S_EXEC) && !r_work.is_short && (r_phase == PH_ONGOING)
                         && r_work.id[31] && (r_count != '0);

    // |transit - previous| minus the current estimate
    always_comb begin
        delta     = r_work.transit - r_prev;
        delta_abs = delta[31] ? 33'd0 - {delta[31], delta} : {1'b0, delta};
        diff      = $signed({1'b0, delta_abs}) - 34'(r_jitter);
    end

    // divide by 16 truncating toward zero, then saturate to 32 bits
    always_comb begin
        diff_rnd = r_diff + (r_diff[33] ? 34'sd15 : 34'sd0);
        jit_sum  = 35'(r_jitter) + 35'(diff_rnd >>> 4);
        if (jit_sum > 35'sh0_7FFF_FFFF) begin
            jit_sat = 32'sh7FFF_FFFF;
        end else if (jit_sum < -35'sh0_8000_0000) begin
            jit_sat = -32'sh8000_0000;
        end else begin
            jit_sat = jit_sum[31:0];
        end
    end

    always_comb begin
        emit_item = '0;
        emit_item.event_kind = r_kind;
        if (r_kind != EV_SHORT) begin
            emit_item.packets_received     = r_count;
            emit_item.packets_lost         = r_lost;
            emit_item.packets_out_of_order = r_reorder;
            emit_item.total_bytes          = r_bytes;
            emit_item.jitter_us            = r_jitter;
        end
        if (r_kind == EV_FINISHED || r_kind == EV_RESENT) begin
            emit_item.duration_us = r_final;
        end
        if (r_kind == EV_FINISHED) begin
            emit_item.average_packet_size = r_avg;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_phase     <= PH_IDLE;
            r_start     <= '0;
            r_count     <= '0;
            r_bytes     <= '0;
            r_lost      <= '0;
            r_reorder   <= '0;
            r_jitter    <= '0;
            r_prev      <= '0;
            r_expected  <= '0;
            r_final     <= '0;
            r_tvalid    <= 1'b0;
            r_div_start <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_div_start <= div_go;
            r_out_valid <= out_load || (r_out_valid && !o_tx.ready);
            case (r_state)
                S_IDLE: begin
                    if (i_pop_valid) begin
                        r_work  <= i_pop_data;
                        r_state <= S_EXEC;
                    end
                end
                S_EXEC: begin
                    if (r_work.is_short) begin
                        r_kind  <= EV_SHORT;
                        r_state <= S_EMIT;
                    end else if (r_phase == PH_ONGOING && r_work.id[31]) begin
                        r_kind  <= EV_FINISHED;
                        r_phase <= PH_COMPLETED;
                        r_final <= r_work.arrival - r_start;
                        r_avg   <= '0;
                        r_state <= div_go ? S_DIV : S_EMIT;
                    end else if (r_phase == PH_ONGOING) begin
                        r_kind   <= EV_COUNTED;
                        r_count  <= r_count + 32'd1;
                        r_bytes  <= r_bytes + 64'(r_work.len);
                        r_prev   <= r_work.transit;
                        r_tvalid <= 1'b1;
                        r_diff   <= diff;
                        r_state  <= r_tvalid ? S_JIT : S_EMIT;
                        if (r_work.id == $signed(r_expected)) begin
                            r_expected <= r_expected + 32'd1;
                        end else if (r_work.id < $signed(r_expected)) begin
                            r_reorder <= r_reorder + 32'd1;
                        end else begin
                            r_lost     <= r_lost + (r_work.id - r_expected);
                            r_expected <= r_work.id + 32'd1;
                        end
                    end else if (r_work.id[31]) begin
                        r_kind  <= EV_RESENT;
                        r_state <= S_EMIT;
                    end else begin
                        r_kind     <= EV_STARTED;
                        r_phase    <= PH_ONGOING;
                        r_start    <= r_work.arrival;
                        r_count    <= '0;
                        r_bytes    <= '0;
                        r_lost     <= '0;
                        r_reorder  <= '0;
                        r_jitter   <= '0;
                        r_prev     <= '0;
                        r_expected <= '0;
                        r_final    <= '0;
                        r_tvalid   <= 1'b0;
                        r_state    <= S_EMIT;
                    end
                end
                S_JIT: begin
                    r_jitter <= jit_sat;
                    r_state  <= S_EMIT;
                end
                S_DIV: begin
                    if (i_div_done) begin
                        r_avg   <= (|i_div_quotient[63:16]) ? 16'hFFFF : i_div_quotient[15:0];
                        r_state <= S_EMIT;
                    end
                end
                S_EMIT: begin
                    if (out_load) begin
                        r_out   <= emit_item;
                        r_state <= S_IDLE;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    assign o_div_start    = r_div_start;
    assign o_div_dividend = r_bytes;
    assign o_div_divisor  = r_count;
    assign o_tx.valid     = r_out_valid;
    assign o_tx.data      = r_out;
endmodule

/* rtl/udp_throughput_session_stats.sv */
// top level: udp receiver session statistics, one result per datagram
// a datagram passes the front register and the queue, then the back end sequencer (pop,
// update, jitter filter when it runs, result load); a finish with counted packets also waits
// for the 64-step average size divide
// the back end sequencer takes a new datagram only when idle, so it handles one at a time
// reset: synchronous active-low; session idle, all statistics zero, queue empty
module udp_throughput_session_stats #(
    parameter int unsigned HEADER_BYTES = 16
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    usts_in_if.sink     i_rx,
    usts_out_if.source  o_tx
);
    import usts_pkg::*;

    logic        push_valid;
    logic        push_ready;
    t_work       push_data;
    logic        pop_valid;
    logic        pop_ready;
    t_work       pop_data;
    logic        div_start;
    logic [63:0] div_dividend;
    logic [31:0] div_divisor;
    logic        div_done;
    logic [63:0] div_quotient;

    usts_front #(
        .HEADER_BYTES(HEADER_BYTES)
    ) u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_rx        (i_rx),
        .o_push_valid(push_valid),
        .i_push_ready(push_ready),
        .o_push_data (push_data)
    );

    usts_queue u_queue (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_push_valid(push_valid),
        .o_push_ready(push_ready),
        .i_push_data (push_data),
        .o_pop_valid (pop_valid),
        .i_pop_ready (pop_ready),
        .o_pop_data  (pop_data)
    );

    usts_div u_div (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_start   (div_start),
        .i_dividend(div_dividend),
        .i_divisor (div_divisor),
        .o_done    (div_done),
        .o_quotient(div_quotient)
    );

    usts_back u_back (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_pop_valid   (pop_valid),
        .o_pop_ready   (pop_ready),
        .i_pop_data    (pop_data),
        .o_div_start   (div_start),
        .o_div_dividend(div_dividend),
        .o_div_divisor (div_divisor),
        .i_div_done    (div_done),
        .i_div_quotient(div_quotient),
        .o_tx          (o_tx)
    );
endmodule

/* tb/testbench.sv */
`timescale 1ns / 1ps
// testbench for udp_throughput_session_stats: directed and random datagrams, scoreboard check
module testbench;
    import usts_pkg::*;

    localparam int unsigned HEADER_LEN   = 16;
    localparam int          CLK_PERIOD   = 10;
    localparam int          ITEM_TARGET  = 1650;
    localparam int          CYCLE_LIMIT  = 600000;
    localparam int          DRAIN_CYCLES = 100;
    localparam int          HOLD_AT      = 500;
    localparam int          LONG_HOLD    = 400;
    localparam longint      JITTER_MAX   = 64'sd2147483647;
    localparam longint      JITTER_MIN   = -64'sd2147483648;

    typedef enum logic [1:0] {
        SESSION_IDLE,
        SESSION_ONGOING,
        SESSION_COMPLETED
    } t_session_phase;

    class session_ledger;
        t_session_phase     phase;
        logic [63:0]        session_origin;
        logic [31:0]        packet_count;
        logic [63:0]        byte_total;
        logic [31:0]        lost_count;
        logic [31:0]        reorder_count;
        logic signed [31:0] jitter;
        logic [31:0]        prev_transit;
        logic signed [31:0] expected_id;
        logic [63:0]        final_duration;
        bit                 transit_valid;
        t_out_item          stats_due[$];
        int                 mismatches;

        function new();
            phase          = SESSION_IDLE;
            session_origin = '0;
            mismatches     = 0;
            clear_stats();
        endfunction

        function void clear_stats();
            packet_count   = '0;
            byte_total     = '0;
            lost_count     = '0;
            reorder_count  = '0;
            jitter         = '0;
            prev_transit   = '0;
            expected_id    = '0;
            final_duration = '0;
            transit_valid  = 1'b0;
        endfunction

        function t_out_item stats_snapshot(logic [2:0] kind, logic [63:0] duration);
            t_out_item r;
            r.event_kind           = kind;
            r.packets_received     = packet_count;
            r.packets_lost         = lost_count;
            r.packets_out_of_order = reorder_count;
            r.total_bytes          = byte_total;
            r.duration_us          = duration;
            r.jitter_us            = jitter;
            r.average_packet_size  = '0;
            return r;
        endfunction

        // one accepted datagram: advance the session and queue its statistics
        function void note_datagram(t_in_item d);
            t_out_item          r;
            logic signed [31:0] id;
            logic [31:0]        sent32;
            logic [31:0]        transit;
            logic signed [31:0] step;
            logic [63:0]        mean;
            longint             diff;
            longint             est;
            id     = d.packet_id;
            sent32 = d.sent_seconds * USEC_PER_SECOND + 32'(d.sent_microseconds);
            if (d.packet_length < HEADER_LEN) begin
                r = '0;
                r.event_kind = EV_SHORT;
            end else if (phase == SESSION_ONGOING) begin
                if (id[31]) begin
                    final_duration = d.arrival_us - session_origin;
                    phase = SESSION_COMPLETED;
                    r = stats_snapshot(EV_FINISHED, final_duration);
                    if (packet_count != 0) begin
                        mean = byte_total / {32'd0, packet_count};
                        r.average_packet_size = (mean > 64'hFFFF) ? 16'hFFFF : mean[15:0];
                    end
                end else begin
                    transit = d.arrival_us[31:0] - sent32;
                    packet_count = packet_count + 1;
                    byte_total = byte_total + {48'd0, d.packet_length};
                    if (transit_valid) begin
                        step = transit - prev_transit;
                        diff = step;
                        if (diff < 0) diff = -diff;
                        est = longint'(jitter) + (diff - longint'(jitter)) / 16;
                        if (est > JITTER_MAX) est = JITTER_MAX;
                        if (est < JITTER_MIN) est = JITTER_MIN;
                        jitter = est[31:0];
                    end
                    prev_transit  = transit;
                    transit_valid = 1'b1;
                    if (id == expected_id) begin
                        expected_id = expected_id + 1;
                    end else if (id < expected_id) begin
                        reorder_count = reorder_count + 1;
                    end else begin
                        lost_count  = lost_count + (id - expected_id);
                        expected_id = id + 1;
                    end
                    r = stats_snapshot(EV_COUNTED, '0);
                end
            end else if (id[31]) begin
                r = stats_snapshot(EV_RESENT, final_duration);
            end else begin
                clear_stats();
                phase          = SESSION_ONGOING;
                session_origin = d.arrival_us;
                r = stats_snapshot(EV_STARTED, '0);
            end
            stats_due.push_back(r);
        endfunction

        function void compare_field(string field, logic [63:0] want, logic [63:0] seen);
            if (want !== seen) begin
                $error("%s mismatch: expected %h, got %h", field, want, seen);
                mismatches++;
            end
        endfunction

        function void check_result(t_out_item got);
            t_out_item want;
            if (stats_due.size() == 0) begin
                $error("result with nothing pending: event_kind %0d", got.event_kind);
                mismatches++;
                return;
            end
            want = stats_due.pop_front();
            compare_field("event_kind", want.event_kind, got.event_kind);
            compare_field("packets_received", want.packets_received, got.packets_received);
            compare_field("packets_lost", want.packets_lost, got.packets_lost);
            compare_field("packets_out_of_order", want.packets_out_of_order,
                          got.packets_out_of_order);
            compare_field("total_bytes", want.total_bytes, got.total_bytes);
            compare_field("duration_us", want.duration_us, got.duration_us);
            compare_field("jitter_us", want.jitter_us, got.jitter_us);
            compare_field("average_packet_size", want.average_packet_size,
                          got.average_packet_size);
        endfunction
    endclass

    logic i_clk = 1'b0;
    logic i_rst_n;

    usts_in_if  rx_if();
    usts_out_if tx_if();

    udp_throughput_session_stats #(
        .HEADER_BYTES(HEADER_LEN)
    ) u_dut (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_rx   (rx_if),
        .o_tx   (tx_if)
    );

    session_ledger ledger = new();

    int          cycle_count   = 0;
    int          send_index    = 0;
    int          counted_items = 0;
    int          results_taken = 0;
    logic [63:0] arrival_clock = '0;

    always #(CLK_PERIOD / 2) i_clk = ~i_clk;

    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("tb: failure");
            $finish;
        end
    end

    // offer one datagram after a random gap and hold it until the transfer
    task automatic send_datagram(input logic signed [31:0] id, input logic [31:0] sec,
                                 input logic [19:0] usec, input logic [15:0] len,
                                 input logic [63:0] arrival);
        t_in_item item;
        int       gap;
        item.packet_id         = id;
        item.sent_seconds      = sec;
        item.sent_microseconds = usec;
        item.packet_length     = len;
        item.arrival_us        = arrival;
        gap = (send_index % 300 < 60) ? 0 : $urandom_range(0, 15);
        if (gap > 0) begin
            rx_if.valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        rx_if.valid <= 1'b1;
        rx_if.data  <= item;
        do @(posedge i_clk); while (!rx_if.ready);
        ledger.note_datagram(item);
        send_index++;
        if (len >= HEADER_LEN) counted_items++;
    endtask

    // advance the receiver clock and stamp the sender time a random delay earlier
    task automatic send_timed(input logic signed [31:0] id, input logic [15:0] len);
        logic [63:0] sent_total;
        logic [31:0] sec;
        logic [19:0] usec;
        arrival_clock = arrival_clock + $urandom_range(1, 4000);
        sent_total = arrival_clock - $urandom_range(0, 30000);
        sec  = 32'(sent_total / 64'd1000000);
        usec = 20'(sent_total % 64'd1000000);
        if ($urandom_range(0, 31) == 0) usec = 20'($urandom);
        send_datagram(id, sec, usec, len, arrival_clock);
    endtask

    initial begin : result_sink
        int stall;
        tx_if.ready <= 1'b0;
        @(posedge i_clk);
        while (!i_rst_n) @(posedge i_clk);
        forever begin
            if (results_taken == HOLD_AT)
                stall = LONG_HOLD;
            else if (results_taken % 300 >= 150 && results_taken % 300 < 210)
                stall = 0;
            else
                stall = $urandom_range(0, 15);
            if (stall > 0) begin
                tx_if.ready <= 1'b0;
                repeat (stall) @(posedge i_clk);
            end
            tx_if.ready <= 1'b1;
            do @(posedge i_clk); while (!tx_if.valid);
            ledger.check_result(tx_if.data);
            results_taken++;
        end
    end

    initial begin : datagram_source
        int                 choice;
        int                 burst;
        int                 roll;
        int                 len_roll;
        logic signed [31:0] next_id;
        logic signed [31:0] id;
        logic [15:0]        len;
        rx_if.valid <= 1'b0;
        rx_if.data  <= '0;
        i_rst_n     <= 1'b0;
        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // idle after reset: resend of empty stats, then short datagrams
        send_datagram(-1, 32'd0, 20'd0, 16'd16, 64'd100);
        send_datagram(0, 32'd0, 20'd0, 16'd0, 64'd200);
        send_datagram(5, 32'd0, 20'd0, 16'(HEADER_LEN - 1), 64'd300);
        // session with in-order, gap, reorder and id wrap
        send_datagram(0, 32'd0, 20'd0, 16'(HEADER_LEN), 64'd1000);
        send_datagram(0, 32'd0, 20'd500, 16'd16, 64'd1600);
        send_datagram(1, 32'd0, 20'd1000, 16'd1500, 64'd2500);
        send_datagram(5, 32'd0, 20'd2000, 16'd700, 64'd2900);
        send_datagram(2, 32'd0, 20'd2100, 16'd64, 64'd3300);
        send_datagram(32'sh7FFF_FFFF, 32'hFFFF_FFFF, 20'hF_FFFF, 16'hFFFF,
                      64'hFFFF_FFFF_FFFF_FFFF);
        send_datagram(3, 32'h5555_5555, 20'hA_AAAA, 16'h8000, 64'h0000_0000_0001_0000);
        send_datagram(7, 32'd0, 20'd0, 16'd8, 64'd4000);
        send_datagram(32'sh8000_0000, 32'd0, 20'd0, 16'hFFFF, 64'd5000);
        // completed: resend, then a session with no packets and a wrapped duration
        send_datagram(-5, 32'd0, 20'd0, 16'd100, 64'd6000);
        send_datagram(9, 32'd0, 20'd0, 16'd100, 64'd9000);
        send_datagram(-1, 32'd0, 20'd0, 16'd100, 64'd100);
        // full-length packets drive the average size to its top
        send_datagram(0, 32'd0, 20'd0, 16'd200, 64'd10);
        send_datagram(0, 32'd0, 20'd5, 16'hFFFF, 64'd20);
        send_datagram(1, 32'd0, 20'd900, 16'hFFFF, 64'd1020);
        send_datagram(-1, 32'd0, 20'd0, 16'd16, 64'd2000);

        arrival_clock = {$urandom, $urandom};
        while (counted_items < ITEM_TARGET) begin
            choice = $urandom_range(0, 9);
            if (choice == 0) begin
                send_datagram($urandom, $urandom, 20'($urandom), 16'($urandom),
                              {$urandom, $urandom});
            end else begin
                if ($urandom_range(0, 7) == 0) arrival_clock = {$urandom, $urandom};
                send_timed(32'($urandom_range(0, 1000)), 16'($urandom_range(16, 1500)));
                next_id = ($urandom_range(0, 15) == 0) ?
                          32'sh7FFF_FFF0 + $urandom_range(0, 8) : 32'sd0;
                burst = ($urandom_range(0, 19) == 0) ? $urandom_range(50, 200)
                                                     : $urandom_range(0, 20);
                for (int k = 0; k < burst; k++) begin
                    roll = $urandom_range(0, 19);
                    if (roll == 0) next_id = next_id + $urandom_range(1, 6);
                    if (roll == 1 && next_id > 3) begin
                        id = next_id - $urandom_range(1, 3);
                    end else begin
                        id = next_id;
                        next_id = next_id + 1;
                    end
                    len_roll = $urandom_range(0, 15);
                    if (len_roll == 0)
                        len = 16'($urandom_range(0, HEADER_LEN - 1));
                    else if (len_roll == 1)
                        len = 16'($urandom);
                    else
                        len = 16'($urandom_range(16, 1500));
                    send_timed(id, len);
                end
                // most sessions end, some also get their stats resent
                if ($urandom_range(0, 5) != 0) begin
                    send_timed({1'b1, 31'($urandom)}, 16'($urandom_range(16, 1500)));
                    if ($urandom_range(0, 3) == 0)
                        send_timed({1'b1, 31'($urandom)}, 16'($urandom_range(16, 1500)));
                end
            end
        end
        rx_if.valid <= 1'b0;

        while (ledger.stats_due.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (ledger.mismatches == 0 && ledger.stats_due.size() == 0)
            $display("tb: success");
        else
            $display("tb: failure");
        $finish;
    end

endmodule
